FILE: hdl/cbwp_pkg.sv
// Shared types, widths and constants of the cubic B-spline wander path core.
// No dependencies; every other file of the core imports this package.
package cbwp_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OFF_W      = 16;

  localparam int T_W    = FRAC_BITS + 2;   // curve parameter, signed
  localparam int STEP_W = FRAC_BITS + 1;   // step size, unsigned
  localparam int TU_W   = FRAC_BITS + 1;   // t, t^2, t^3 while in [0, 1.0]
  localparam int WGT_W  = FRAC_BITS + 4;   // blend weight, signed, up to 4.0

  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 40;

  // Divide by 6 via reciprocal: exact for dividends below 2^(RECIP_SH-2)
  localparam int QIN_W    = 22;
  localparam int QUO_W    = 21;
  localparam int RECIP_SH = 25;
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(((1 << RECIP_SH) + 5) / 6);

  localparam logic [QUO_W-1:0] QMAX_POS = QUO_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic [QUO_W-1:0] QMAX_NEG = QUO_W'(1 << (COORD_BITS - 1));

  localparam logic signed [T_W-1:0] ONE_T = T_W'(1 << FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(6554);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = STEP_W;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_TOP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_RIGHT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_BOTTOM = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef struct packed {
    logic             append;
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
  } app_req_t;

endpackage

FILE: hdl/cbwp_mul.sv
// Shared signed multiplier with a registered product.
// Depends on cbwp_pkg for operand and product widths.
module cbwp_mul (
  input  logic                               clk,
  input  logic signed [cbwp_pkg::MUL_W-1:0]  mul_a,
  input  logic signed [cbwp_pkg::MUL_W-1:0]  mul_b,
  output logic signed [cbwp_pkg::PROD_W-1:0] prod
);
  import cbwp_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

FILE: hdl/cbwp_pts.sv
// Control point store: four points, oldest at index 0, with clamped append.
// Depends on cbwp_pkg for coordinate, rectangle and append request types.
module cbwp_pts (
  input  logic                clk,
  input  logic                rst_n,
  input  cbwp_pkg::rect_t     rect,
  input  cbwp_pkg::app_req_t  app,
  output cbwp_pkg::coord_t    pt_x [4],
  output cbwp_pkg::coord_t    pt_y [4]
);
  import cbwp_pkg::*;

  localparam logic signed [COORD_BITS:0] SPAN_ONE = 1;

  coord_t pt_x_r [4];
  coord_t pt_y_r [4];
  coord_t new_x;
  coord_t new_y;

  // Origin plus offset; offset clamped to span - 1, zero for an empty span
  function automatic coord_t new_coord(coord_t lo, coord_t hi, logic [OFF_W-1:0] off);
    logic signed [COORD_BITS:0] span;
    logic signed [COORD_BITS:0] offs;
    logic signed [COORD_BITS:0] sum;
    span = (COORD_BITS+1)'(hi) - (COORD_BITS+1)'(lo);
    offs = (COORD_BITS+1)'(off);
    if (span <= 0) begin
      offs = '0;
    end else if (offs >= span) begin
      offs = span - SPAN_ONE;
    end
    sum = (COORD_BITS+1)'(lo) + offs;
    return sum[COORD_BITS-1:0];
  endfunction

  assign new_x = new_coord(rect.left, rect.right, app.off_x);
  assign new_y = new_coord(rect.top, rect.bottom, app.off_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        pt_x_r[i] <= '0;
        pt_y_r[i] <= '0;
      end
    end else if (app.append) begin
      for (int i = 0; i < 3; i++) begin
        pt_x_r[i] <= pt_x_r[i+1];
        pt_y_r[i] <= pt_y_r[i+1];
      end
      pt_x_r[3] <= new_x;
      pt_y_r[3] <= new_y;
    end
  end

  assign pt_x = pt_x_r;
  assign pt_y = pt_y_r;

endmodule

FILE: hdl/cubic_bspline_wander_path_core.sv
// Top level of the cubic B-spline wander path core: sequencer, registers, output stage.
// Depends on cbwp_pkg, cbwp_mul (shared multiplier) and cbwp_pts (control points).
//
//  channel | ports                    | word layout (low bit first)
//  --------+--------------------------+----------------------------------------
//  in      | in_tvalid/tready/tdata   | tdata: offset_x[15:0], offset_y[31:16]
//          | in_tuser                 | tuser: op (0 load point, 1 tick)
//  out     | out_tvalid/tready/tdata  | tdata: pos_x[15:0], pos_y[31:16]
//  cfg     | cfg_we/addr/wdata        | addr = register index, wdata[16:0]
//
// A load word leaves the input ready for the next word. A tick word keeps the input busy
// through the steps t^2, t^3 and weights, then per axis four multiply-accumulates and
// one reciprocal multiply, all on the one shared multiplier, then a step that hands
// the word to the output register. Output stalls hold the core in that last step.
// Reset (rst_n low, synchronous) zeroes the points and rectangle, sets t to 1.0.
module cubic_bspline_wander_path_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,   // offset_x, offset_y
  input  logic                                in_tuser,   // op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // pos_x, pos_y
  input  logic                                cfg_we,
  input  logic [cbwp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cbwp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cbwp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_T2   = 3'd1;
  localparam logic [2:0] ST_T3   = 3'd2;
  localparam logic [2:0] ST_WGT  = 3'd3;
  localparam logic [2:0] ST_MAC  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_QUO  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [2:0] MAC_LAST = 3'd4;

  localparam logic signed [WGT_W-1:0] K3    = 3;
  localparam logic signed [WGT_W-1:0] K6    = 6;
  localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(1 << FRAC_BITS);
  localparam logic signed [WGT_W-1:0] FOUR_W = WGT_W'(4 << FRAC_BITS);

  // control state
  logic [2:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       axis_r, axis_nxt;
  logic       out_valid_r;
  logic signed [T_W-1:0] curve_r, curve_nxt;
  rect_t               rect_r;
  logic [STEP_W-1:0]   step_r;

  // payload
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic [TU_W-1:0]         t2_r, t2_nxt;
  logic signed [WGT_W-1:0] w_r [4];
  coord_t                  res_x_r, res_x_nxt;
  coord_t                  res_y_r, res_y_nxt;
  coord_t                  out_x_r, out_y_r;

  logic                    in_acc;
  logic                    load_out;
  logic                    wgt_load;
  app_req_t                app;
  coord_t                  pt_x [4];
  coord_t                  pt_y [4];
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [TU_W-1:0]         t_val;
  logic [TU_W-1:0]         prod_hi;
  logic signed [WGT_W-1:0] e_t, e_t2, e_t3;
  logic signed [WGT_W-1:0] w_new [4];
  logic [ACC_W-1:0]        mag;
  logic [QIN_W-1:0]        qin;
  logic [QUO_W-1:0]        quo;
  coord_t                  quo_res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // A load always appends; a tick appends only once t has run below zero
  assign app.append = in_acc && ((in_tuser == OP_LOAD) || curve_r[T_W-1]);
  assign app.off_x  = in_tdata[OFF_W-1:0];
  assign app.off_y  = in_tdata[2*OFF_W-1:OFF_W];

  cbwp_pts u_pts (
    .clk   (clk),
    .rst_n (rst_n),
    .rect  (rect_r),
    .app   (app),
    .pt_x  (pt_x),
    .pt_y  (pt_y)
  );

  cbwp_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign t_val   = curve_r[TU_W-1:0];
  assign prod_hi = prod[FRAC_BITS+TU_W-1:FRAC_BITS];

  // Six times the blend weights, t3 taken straight from the product register
  assign e_t  = WGT_W'(t_val);
  assign e_t2 = WGT_W'(t2_r);
  assign e_t3 = WGT_W'(prod_hi);
  assign w_new[0] = e_t3;
  assign w_new[1] = ONE_W + K3 * e_t - K3 * e_t3 + K3 * e_t2;
  assign w_new[2] = FOUR_W + K3 * e_t3 - K6 * e_t2;
  assign w_new[3] = ONE_W - e_t3 + K3 * e_t2 - K3 * e_t;

  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign qin = mag[FRAC_BITS+QIN_W-1:FRAC_BITS];
  assign quo = prod[RECIP_SH+QUO_W-1:RECIP_SH];

  // Apply sign and saturate to the coordinate range
  always_comb begin
    if (!neg_r) begin
      quo_res = (quo > QMAX_POS) ? coord_t'(QMAX_POS[COORD_BITS-1:0])
                                 : coord_t'(quo[COORD_BITS-1:0]);
    end else begin
      quo_res = (quo > QMAX_NEG) ? coord_t'(QMAX_NEG[COORD_BITS-1:0])
                                 : coord_t'(-quo[COORD_BITS-1:0]);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_T2: begin
        mul_a = MUL_W'(t_val);
        mul_b = MUL_W'(t_val);
      end
      ST_T3: begin
        mul_a = MUL_W'(prod_hi);
        mul_b = MUL_W'(t_val);
      end
      ST_MAC: begin
        if (k_r != MAC_LAST) begin
          mul_a = MUL_W'(w_r[k_r[1:0]]);
          mul_b = axis_r ? MUL_W'(pt_y[k_r[1:0]]) : MUL_W'(pt_x[k_r[1:0]]);
        end
      end
      ST_DIV: begin
        mul_a = MUL_W'(qin);
        mul_b = RECIP;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    axis_nxt  = axis_r;
    curve_nxt = curve_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    t2_nxt    = t2_r;
    res_x_nxt = res_x_r;
    res_y_nxt = res_y_r;
    wgt_load  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_LOAD) begin
            curve_nxt = ONE_T;
          end else begin
            if (curve_r[T_W-1]) begin
              curve_nxt = ONE_T;
            end
            state_nxt = ST_T2;
          end
        end
      end
      ST_T2: begin
        state_nxt = ST_T3;
      end
      ST_T3: begin
        t2_nxt    = prod_hi;
        state_nxt = ST_WGT;
      end
      ST_WGT: begin
        wgt_load  = 1'b1;
        k_nxt     = '0;
        axis_nxt  = 1'b0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        // product of step k-1 lands while step k issues
        acc_nxt = (k_r == '0) ? '0 : acc_r + ACC_W'(prod);
        if (k_r == MAC_LAST) begin
          k_nxt     = '0;
          state_nxt = ST_DIV;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_DIV: begin
        neg_nxt   = acc_r[ACC_W-1];
        state_nxt = ST_QUO;
      end
      ST_QUO: begin
        if (!axis_r) begin
          res_x_nxt = quo_res;
          axis_nxt  = 1'b1;
          state_nxt = ST_MAC;
        end else begin
          res_y_nxt = quo_res;
          axis_nxt  = 1'b0;
          curve_nxt = curve_r - $signed(T_W'(step_r));
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      axis_r      <= 1'b0;
      curve_r     <= ONE_T;
      out_valid_r <= 1'b0;
      rect_r      <= '0;
      step_r      <= STEP_RESET;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      axis_r  <= axis_nxt;
      curve_r <= curve_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_RECT_LEFT:   rect_r.left   <= cfg_wdata[COORD_BITS-1:0];
          REG_RECT_TOP:    rect_r.top    <= cfg_wdata[COORD_BITS-1:0];
          REG_RECT_RIGHT:  rect_r.right  <= cfg_wdata[COORD_BITS-1:0];
          REG_RECT_BOTTOM: rect_r.bottom <= cfg_wdata[COORD_BITS-1:0];
          REG_STEP_SIZE:   step_r        <= cfg_wdata[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    t2_r    <= t2_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
    if (wgt_load) begin
      for (int i = 0; i < 4; i++) begin
        w_r[i] <= w_new[i];
      end
    end
    if (load_out) begin
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};

`ifndef SYNTH
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_TICK)) |=> !in_tready)
    else $error("tick word did not hold off the input");

  a_load_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_LOAD)) |=> (curve_r == ONE_T))
    else $error("load word did not rewind t to 1.0");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T2 || state_r == ST_T3 || state_r == ST_WGT)
      |-> (!curve_r[T_W-1] && (curve_r <= ONE_T)))
    else $error("t outside [0, 1.0] during evaluation");
`endif

endmodule
